// File: design/ngpe_pkg.sv
package ngpe_pkg;

  // Field widths of the byte stream and the captured characters
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 4;

  // Default field lengths, in characters
  localparam int unsigned LatCharsDef = 9;
  localparam int unsigned LonCharsDef = 10;

  // Characters of the sentence header and the field separator
  localparam logic [ByteW-1:0] ChrDollar = 8'h24;
  localparam logic [ByteW-1:0] ChrG      = 8'h47;
  localparam logic [ByteW-1:0] ChrP      = 8'h50;
  localparam logic [ByteW-1:0] ChrA      = 8'h41;
  localparam logic [ByteW-1:0] ChrComma  = 8'h2c;

  // Field codes carried on field_id
  localparam logic FieldLat = 1'b0;
  localparam logic FieldLon = 1'b1;

endpackage

// File: design/nmea_gga_position_extractor.sv
// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  ---------------------------------------
// in        sink       in_valid_i / in_stall_o  rx_byte_i
// out       source     out_valid_o/out_stall_i  field_id_o, char_pos_o, char_value_o,
//                                               field_last_o
//
// One byte is taken per cycle; the header match and field capture state update
// in the cycle of acceptance, and a captured character appears on the result
// register in the next cycle. Reset returns the parser to hunting for '$' and
// empties the result register. in_stall_o rises only while a result is held
// under out_stall_i; a byte that yields no result still waits behind it.
module nmea_gga_position_extractor #(
  parameter int unsigned LAT_CHARS = ngpe_pkg::LatCharsDef,
  parameter int unsigned LON_CHARS = ngpe_pkg::LonCharsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ngpe_pkg::ByteW-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       field_id_o,
  output logic [ngpe_pkg::PosW-1:0]  char_pos_o,
  output logic [ngpe_pkg::ByteW-1:0] char_value_o,
  output logic                       field_last_o
);
  import ngpe_pkg::*;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned SumW   = PosW + 1;

  localparam logic [PhaseW-1:0] PhDollar = 4'd0;
  localparam logic [PhaseW-1:0] PhG1     = 4'd1;
  localparam logic [PhaseW-1:0] PhP      = 4'd2;
  localparam logic [PhaseW-1:0] PhG2     = 4'd3;
  localparam logic [PhaseW-1:0] PhG3     = 4'd4;
  localparam logic [PhaseW-1:0] PhA      = 4'd5;
  localparam logic [PhaseW-1:0] PhComma1 = 4'd6;
  localparam logic [PhaseW-1:0] PhTime   = 4'd7;
  localparam logic [PhaseW-1:0] PhLat    = 4'd8;
  localparam logic [PhaseW-1:0] PhComma2 = 4'd9;
  localparam logic [PhaseW-1:0] PhSkip   = 4'd10;
  localparam logic [PhaseW-1:0] PhLon    = 4'd11;
  localparam logic [PhaseW-1:0] PhTail   = 4'd12;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PosW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q;
  logic              field_id_q, field_id_d;
  logic [PosW-1:0]   char_pos_q;
  logic [ByteW-1:0]  char_value_q;
  logic              field_last_q, field_last_d;
  logic              in_acc;
  logic              emit;
  logic              lat_last;
  logic              lon_last;
  logic [SumW-1:0]   cnt_inc;

  // Hold the input while a result waits under stall
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Detect the last character of each captured field
  assign cnt_inc  = {1'b0, cnt_q} + SumW'(1);
  assign lat_last = cnt_inc >= SumW'(LAT_CHARS);
  assign lon_last = cnt_inc >= SumW'(LON_CHARS);

  // Advance the parser on each accepted byte
  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    emit         = 1'b0;
    field_id_d   = FieldLat;
    field_last_d = 1'b0;
    if (in_acc) begin
      case (phase_q)
        PhG1:     phase_d = (rx_byte_i == ChrG)     ? PhP      : PhDollar;
        PhP:      phase_d = (rx_byte_i == ChrP)     ? PhG2     : PhDollar;
        PhG2:     phase_d = (rx_byte_i == ChrG)     ? PhG3     : PhDollar;
        PhG3:     phase_d = (rx_byte_i == ChrG)     ? PhA      : PhDollar;
        PhA:      phase_d = (rx_byte_i == ChrA)     ? PhComma1 : PhDollar;
        PhComma1: phase_d = (rx_byte_i == ChrComma) ? PhTime   : PhDollar;
        PhTime: begin
          if (rx_byte_i == ChrComma) begin
            phase_d = PhLat;
            cnt_d   = '0;
          end
        end
        PhLat: begin
          emit         = 1'b1;
          field_id_d   = FieldLat;
          field_last_d = lat_last;
          if (lat_last) begin
            phase_d = PhComma2;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc[PosW-1:0];
          end
        end
        PhComma2: phase_d = (rx_byte_i == ChrComma) ? PhSkip : PhDollar;
        PhSkip: begin
          if (rx_byte_i == ChrComma) begin
            phase_d = PhLon;
            cnt_d   = '0;
          end
        end
        PhLon: begin
          emit         = 1'b1;
          field_id_d   = FieldLon;
          field_last_d = lon_last;
          if (lon_last) begin
            phase_d = PhTail;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc[PosW-1:0];
          end
        end
        PhTail: begin
          phase_d = PhDollar;
          cnt_d   = '0;
        end
        default: begin
          phase_d = (rx_byte_i == ChrDollar) ? PhG1 : PhDollar;
          cnt_d   = '0;
        end
      endcase
    end
  end

  // Update parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDollar;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Load the result request unless one is held under stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_acc & emit;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      field_id_q   <= field_id_d;
      char_pos_q   <= cnt_q;
      char_value_q <= rx_byte_i;
      field_last_q <= field_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign field_id_o   = field_id_q;
  assign char_pos_o   = char_pos_q;
  assign char_value_o = char_value_q;
  assign field_last_o = field_last_q;

endmodule

// File: verif/tb.sv
module tb;
  import ngpe_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_G1, PH_P, PH_G2, PH_G3, PH_A, PH_COMMA1,
    PH_TIME, PH_LAT, PH_COMMA2, PH_SKIP, PH_LON, PH_TAIL
  } gga_phase_e;

  typedef struct packed {
    logic             field_id;
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] value;
    logic             last;
  } gga_char_t;

  // Tracks the parser state and the captured characters still owed by the block
  class gga_scoreboard;
    gga_phase_e  phase;
    logic [3:0]  count;
    gga_char_t   expected_chars[$];
    int unsigned errors;

    function new();
      phase  = PH_HUNT;
      count  = '0;
      errors = 0;
    endfunction

    // Advance on a header or separator byte, or fall back to the hunt
    function void match(logic [ByteW-1:0] b, logic [ByteW-1:0] want, gga_phase_e nxt);
      phase = (b == want) ? nxt : PH_HUNT;
    endfunction

    // Step the parser on one accepted request and queue any captured character
    function void note_rx_byte(logic [ByteW-1:0] b);
      gga_char_t c;
      int        limit;
      case (phase)
        PH_G1:     match(b, ChrG, PH_P);
        PH_P:      match(b, ChrP, PH_G2);
        PH_G2:     match(b, ChrG, PH_G3);
        PH_G3:     match(b, ChrG, PH_A);
        PH_A:      match(b, ChrA, PH_COMMA1);
        PH_COMMA1: match(b, ChrComma, PH_TIME);
        PH_COMMA2: match(b, ChrComma, PH_SKIP);
        PH_TIME, PH_SKIP: begin
          if (b == ChrComma) begin
            phase = (phase == PH_TIME) ? PH_LAT : PH_LON;
            count = '0;
          end
        end
        PH_LAT, PH_LON: begin
          limit      = (phase == PH_LAT) ? LatCharsDef : LonCharsDef;
          c.field_id = (phase == PH_LAT) ? FieldLat : FieldLon;
          c.pos      = count;
          c.value    = b;
          c.last     = (int'(count) + 1 >= limit);
          expected_chars.push_back(c);
          if (c.last) begin
            phase = (phase == PH_LAT) ? PH_COMMA2 : PH_TAIL;
            count = '0;
          end else begin
            count = count + 1'b1;
          end
        end
        PH_TAIL: begin
          phase = PH_HUNT;
          count = '0;
        end
        default: begin
          phase = (b == ChrDollar) ? PH_G1 : PH_HUNT;
          count = '0;
        end
      endcase
    endfunction

    // Compare one accepted result against the oldest captured character
    function void check_char(gga_char_t got);
      gga_char_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char fid=%0d pos=%0d val=%02h last=%0d",
                 $time, got.field_id, got.pos, got.value, got.last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (got !== want) begin
        $display("%0t: char mismatch, expected fid=%0d pos=%0d val=%02h last=%0d,",
                 $time, want.field_id, want.pos, want.value, want.last,
                 " actual fid=%0d pos=%0d val=%02h last=%0d",
                 got.field_id, got.pos, got.value, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] rx_byte_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             field_id_o;
  logic [PosW-1:0]  char_pos_o;
  logic [ByteW-1:0] char_value_o;
  logic             field_last_o;

  gga_scoreboard sb = new();
  bit            jitter;
  bit            hold_request;
  int unsigned   bytes_sent;

  nmea_gga_position_extractor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .field_id_o   (field_id_o),
    .char_pos_o   (char_pos_o),
    .char_value_o (char_value_o),
    .field_last_o (field_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one byte, hold it until accepted, and log it with the scoreboard
  task automatic send_byte(logic [ByteW-1:0] b);
    if (jitter && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [ByteW-1:0] random_byte();
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic logic [ByteW-1:0] random_non_comma();
    logic [ByteW-1:0] b;
    do b = random_byte(); while (b == ChrComma);
    return b;
  endfunction

  // Build and send one sentence: mostly well formed, some broken or plain noise
  task automatic send_sentence();
    logic [ByteW-1:0] q[$];
    logic [ByteW-1:0] b;
    int               kind;
    int               cut;
    kind = $urandom_range(0, 99);
    q = '{ChrDollar, ChrG, ChrP, ChrG, ChrG, ChrA, ChrComma};
    if (kind >= 92) begin
      q.delete();
      repeat ($urandom_range(1, 8)) q.push_back(random_byte());
    end else if (kind >= 80) begin
      // Break the header at a random spot, sometimes with a fresh dollar sign
      cut = $urandom_range(1, 6);
      do begin
        b = ($urandom_range(0, 2) == 0) ? ChrDollar : random_byte();
      end while (b == q[cut]);
      q = q[0:cut-1];
      q.push_back(b);
    end else begin
      repeat ($urandom_range(0, 6)) q.push_back(random_non_comma());
      q.push_back(ChrComma);
      repeat (LatCharsDef) q.push_back(random_byte());
      if (kind >= 70) begin
        q.push_back(random_non_comma());
      end else begin
        q.push_back(ChrComma);
        repeat ($urandom_range(0, 4)) q.push_back(random_non_comma());
        q.push_back(ChrComma);
        repeat (LonCharsDef) q.push_back(random_byte());
        q.push_back(random_byte());
      end
    end
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Check every result taken by the receiver
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_char('{field_id_o, char_pos_o, char_value_o, field_last_o});
    end
  end

  // Drive receiver stalls: random bursts, plus one long hold on request
  initial begin
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i  <= 1'b0;
        hold_request = 1'b0;
        @(posedge clk_i);
      end else if (jitter && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [ByteW-1:0] directed[$];
    int               sentence;
    jitter       = 1'b0;
    hold_request = 1'b0;
    bytes_sent   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Header broken by a dollar sign, then a sentence with empty time and skip
    // fields and extreme character values
    directed = '{ChrDollar, ChrG, ChrP, ChrDollar,
                 ChrDollar, ChrG, ChrP, ChrG, ChrG, ChrA, ChrComma, ChrComma,
                 8'h00, 8'hff, ChrComma, ChrDollar, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f,
                 ChrComma, ChrComma,
                 8'hff, 8'h00, ChrComma, 8'h30, 8'h39, 8'h2e, 8'hfe, 8'h02, 8'h40, 8'hbf,
                 8'h2a};
    foreach (directed[i]) send_byte(directed[i]);

    sentence = 0;
    while (bytes_sent < 750) begin
      jitter = (bytes_sent < 650) && ($urandom_range(0, 3) != 0);
      if (sentence == 3) hold_request = 1'b1;
      if (sentence == 6) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
      send_sentence();
      sentence++;
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: nmea_gga_position_extractor.f
design/ngpe_pkg.sv
design/nmea_gga_position_extractor.sv
verif/tb.sv
